FILE: design/http_request_header_scanner_unit_macros.svh
// ----------------------------------------------------------------------------
// http request header scanner assertion macros
// shared concurrent assertion shorthands for the scanner modules
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_SCANNER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEADER_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HDRS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hdrs assertion failed");

// next-cycle implication, disabled while in reset
`define HDRS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hdrs assertion failed");

`endif

FILE: design/hdrs_pkg.sv
// ----------------------------------------------------------------------------
// hdrs_pkg
// types, constants and prefix table for the http request header scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdrs_pkg;

    localparam int PAYLOAD_MAX_DEF = 2048;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // candidate bits of the line prefix tracker
    localparam int CAND_POST = 0;
    localparam int CAND_GET  = 1;
    localparam int CAND_HOST = 2;
    localparam logic [2:0] CAND_ALL = 3'b111;

    // method codes
    localparam logic [1:0] METHOD_NONE = 2'd0;
    localparam logic [1:0] METHOD_GET  = 2'd1;
    localparam logic [1:0] METHOD_POST = 2'd2;

    // configuration register indexes
    localparam logic CFG_HTTP_PORT = 1'b0;
    localparam logic CFG_MIN_LEN   = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [11:0] payload_len;
        logic        is_tcp;
        logic [15:0] src_port;
        logic [15:0] dest_port;
    } hdrs_item_t;

    typedef struct packed {
        logic [15:0] http_port;
        logic [11:0] min_payload_len;
    } hdrs_cfg_t;

    typedef struct packed {
        logic        request_found;
        logic [1:0]  method;
        logic [10:0] url_offset;
        logic [10:0] url_len;
        logic        host_found;
        logic [10:0] host_offset;
        logic [10:0] host_length;
        logic        body_found;
        logic [11:0] body_offset;
        logic [11:0] body_len;
    } hdrs_result_t;

    // per candidate: still matching after byte b at line offset off
    // offsets past a candidate's prefix keep it alive
    function automatic logic [2:0] prefix_keep(logic [2:0] off, logic [7:0] b);
        logic [2:0] keep;
        keep = CAND_ALL;
        case (off)
            3'd0: keep = {b == 8'h48, b == 8'h47, b == 8'h50};    // H G P
            3'd1: keep = {b == 8'h6f, b == 8'h45, b == 8'h4f};    // o E O
            3'd2: keep = {b == 8'h73, b == 8'h54, b == 8'h53};    // s T S
            3'd3: keep = {b == 8'h74, b == 8'h20, b == 8'h54};    // t sp T
            3'd4: keep = {b == 8'h3a, 1'b1, b == 8'h20};          // : - sp
            3'd5: keep = {b == 8'h20, 1'b1, 1'b1};                // sp - -
            default: keep = CAND_ALL;
        endcase
        return keep;
    endfunction

endpackage

FILE: design/hdrs_in_stage.sv
// ----------------------------------------------------------------------------
// hdrs_in_stage
// input register of the scanner, holds one item until the scan takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrs_in_stage
    import hdrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  hdrs_item_t in_item,
    input  logic       advance,
    output logic       st_valid,
    output hdrs_item_t st_item
);

    logic       valid_reg, valid_next;
    hdrs_item_t item_reg, item_next;

    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                item_next = in_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign st_valid = valid_reg;
    assign st_item  = item_reg;

endmodule

FILE: design/hdrs_scan.sv
// ----------------------------------------------------------------------------
// hdrs_scan
// per-packet scan state and the single-pass line / prefix / crlf logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrs_scan
    import hdrs_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  hdrs_cfg_t    cfg,
    input  hdrs_item_t   item,
    input  logic         fire,
    output hdrs_result_t result
);

    localparam int POS_W  = $clog2(PAYLOAD_MAX + 1);
    localparam int CALC_W = ((POS_W > 12) ? POS_W : 12) + 2;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  line_start_reg, line_start_next;
    logic [2:0]        cand_reg, cand_next;
    logic [7:0]        recent_reg [3];
    logic [7:0]        recent_next [3];
    logic              done_reg, done_next;
    hdrs_result_t      held_reg, held_next;

    logic              scan_en;
    logic [POS_W-1:0]  off;
    logic [2:0]        off_small;
    logic [2:0]        cand_trk;
    logic              crlf, body_hit, line_hit;
    logic [CALC_W-1:0] pos_x, ls_x, len_x;
    logic [CALC_W-1:0] span_x, body_off_x, body_len_x;

    assign pos_x = CALC_W'(pos_reg);
    assign ls_x  = CALC_W'(line_start_reg);
    assign len_x = CALC_W'(item.payload_len);

    assign scan_en = item.is_tcp
                  && (item.payload_len >= cfg.min_payload_len)
                  && ((item.src_port == cfg.http_port) || (item.dest_port == cfg.http_port))
                  && !done_reg
                  && (pos_reg < POS_W'(PAYLOAD_MAX))
                  && (pos_reg >= line_start_reg);

    assign off       = pos_reg - line_start_reg;
    assign off_small = (off < POS_W'(6)) ? off[2:0] : 3'd7;
    assign cand_trk  = cand_reg & prefix_keep(off_small, item.data_byte);

    assign crlf     = (item.data_byte == CH_LF) && (recent_reg[0] == CH_CR);
    assign body_hit = crlf && (pos_reg >= POS_W'(3)) && (recent_reg[2] == CH_CR)
                   && (recent_reg[1] == CH_LF) && ((pos_x + CALC_W'(1)) < len_x);
    assign line_hit = crlf && !body_hit && ((pos_x + CALC_W'(3)) < len_x);

    // position minus line start; prefix lengths are taken off below
    assign span_x     = pos_x - ls_x;
    assign body_off_x = pos_x + CALC_W'(1);
    assign body_len_x = len_x - pos_x - CALC_W'(1);

    always_comb begin
        held_next       = held_reg;
        cand_next       = cand_reg;
        done_next       = done_reg;
        line_start_next = line_start_reg;
        if (scan_en) begin
            cand_next = cand_trk;
            if (body_hit) begin
                done_next             = 1'b1;
                held_next.body_found  = 1'b1;
                held_next.body_offset = body_off_x[11:0];
                held_next.body_len    = body_len_x[11:0];
            end else if (line_hit) begin
                if (cand_trk[CAND_POST]) begin
                    held_next.request_found = 1'b1;
                    held_next.method        = METHOD_POST;
                    held_next.url_offset    = 11'(ls_x + CALC_W'(5));
                    held_next.url_len       = 11'(span_x - CALC_W'(6));
                end else if (cand_trk[CAND_GET]) begin
                    held_next.request_found = 1'b1;
                    held_next.method        = METHOD_GET;
                    held_next.url_offset    = 11'(ls_x + CALC_W'(4));
                    held_next.url_len       = 11'(span_x - CALC_W'(5));
                end else if (cand_trk[CAND_HOST]) begin
                    held_next.host_found  = 1'b1;
                    held_next.host_offset = 11'(ls_x + CALC_W'(6));
                    held_next.host_length = 11'(span_x - CALC_W'(7));
                end
                line_start_next = pos_reg + POS_W'(1);
                cand_next       = CAND_ALL;
            end
        end
        recent_next[2] = recent_reg[1];
        recent_next[1] = recent_reg[0];
        recent_next[0] = item.data_byte;
        pos_next = (pos_reg < POS_W'(PAYLOAD_MAX)) ? pos_reg + POS_W'(1) : pos_reg;
    end

    assign result = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last_byte)) begin
            pos_reg        <= '0;
            line_start_reg <= '0;
            cand_reg       <= CAND_ALL;
            recent_reg[0]  <= '0;
            recent_reg[1]  <= '0;
            recent_reg[2]  <= '0;
            done_reg       <= 1'b0;
            held_reg       <= '0;
        end else if (fire) begin
            pos_reg        <= pos_next;
            line_start_reg <= line_start_next;
            cand_reg       <= cand_next;
            recent_reg[0]  <= recent_next[0];
            recent_reg[1]  <= recent_next[1];
            recent_reg[2]  <= recent_next[2];
            done_reg       <= done_next;
            held_reg       <= held_next;
        end
    end

endmodule

FILE: design/http_request_header_scanner_unit.sv
// ----------------------------------------------------------------------------
// http_request_header_scanner_unit
// per-byte http request header scanner with a one-item result per packet
// ----------------------------------------------------------------------------
// Payload bytes stream in one item per clock and are scanned for CR LF
// terminated header lines: a "POST " or "GET " line records method, url offset
// and length (a later one wins), a "Host: " line records the host value, and
// a blank line ends the header and records the body offset and length. One
// result item is offered on m_ after the packet's last byte has passed the
// input register into the result register, unless the previous result is
// still waiting there. The block sustains one byte per cycle: each byte
// passes an input register, the scan logic, and, for the last byte, the
// result register. Input stalls only when a last byte sits in the input
// register while the result register still holds an untaken result.
`timescale 1ns / 1ps

`include "http_request_header_scanner_unit_macros.svh"

module http_request_header_scanner_unit
    import hdrs_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // data_byte[7:0], payload_len[19:8], src_port[35:20], dest_port[51:36], zero pad
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // is_tcp
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // request_found[0], method[2:1], url_offset[13:3], url_len[24:14],
    // host_found[25], host_offset[36:26], host_length[47:37], body_found[48],
    // body_offset[60:49], body_len[72:61], zero pad
    output logic [79:0] m_tdata,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wr_data
);

    hdrs_cfg_t    cfg_reg;
    hdrs_item_t   in_item, st_item;
    logic         st_valid;
    logic         advance;
    hdrs_result_t scan_result;
    logic         out_valid_reg, out_valid_next;
    hdrs_result_t out_reg, out_next;

    // configuration registers, the user must write them only while the block is idle; not enforced here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.http_port       <= 16'd80;
            cfg_reg.min_payload_len <= 12'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_HTTP_PORT: cfg_reg.http_port       <= cfg_wr_data;
                CFG_MIN_LEN:   cfg_reg.min_payload_len <= cfg_wr_data[11:0];
                default: ;
            endcase
        end
    end

    // unpack the input item
    always_comb begin
        in_item.data_byte   = s_tdata[7:0];
        in_item.last_byte   = s_tlast;
        in_item.payload_len = s_tdata[19:8];
        in_item.is_tcp      = s_tuser;
        in_item.src_port    = s_tdata[35:20];
        in_item.dest_port   = s_tdata[51:36];
    end

    // the held item moves on unless it is a last byte and the result slot is busy
    assign advance = st_valid && (!st_item.last_byte || !out_valid_reg || m_tready);

    hdrs_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .advance  (advance),
        .st_valid (st_valid),
        .st_item  (st_item)
    );

    hdrs_scan #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (st_item),
        .fire    (advance),
        .result  (scan_result)
    );

    // result register: loaded on the packet's last byte, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && st_item.last_byte) begin
            out_valid_next = 1'b1;
            out_next       = scan_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.body_len, out_reg.body_offset, out_reg.body_found,
                       out_reg.host_length, out_reg.host_offset, out_reg.host_found,
                       out_reg.url_len, out_reg.url_offset, out_reg.method,
                       out_reg.request_found};

    // a new result only ever follows a last byte leaving the input register
    `HDRS_ASSERT_IMP(a_result_from_last, aclk, aresetn, $rose(m_tvalid), $past(advance && st_item.last_byte))
    // a last byte never overwrites an untaken result
    `HDRS_ASSERT_IMP(a_no_result_overrun, aclk, aresetn, m_tvalid && !m_tready && st_valid && st_item.last_byte, !advance)
    // request flag and method code agree
    `HDRS_ASSERT_IMP(a_method_consistent, aclk, aresetn, m_tvalid, out_reg.request_found == (out_reg.method != METHOD_NONE))
    // the body offset stays zero unless the blank line was found
    `HDRS_ASSERT_IMP(a_body_zero, aclk, aresetn, m_tvalid && !out_reg.body_found, out_reg.body_offset == 12'd0)
    // a taken result with no new last byte leaves the slot empty
    `HDRS_ASSERT_NXT(a_slot_drains, aclk, aresetn, m_tvalid && m_tready && !(advance && st_item.last_byte), !m_tvalid)

endmodule

FILE: bench/hdrs_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// hdrs_scoreboard_pkg
// header scan prediction and result checking for the scanner testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdrs_scoreboard_pkg;

    import hdrs_pkg::*;

    class hdrs_scoreboard;

        // register copies
        logic [15:0] http_port;
        logic [11:0] min_len;

        // per packet scan state
        int unsigned  pos;
        int unsigned  line_start;
        logic [2:0]   alive;
        logic [7:0]   recent [3];
        bit           hdr_done;
        hdrs_result_t held;

        hdrs_result_t expected_q[$];

        string post_txt;
        string get_txt;
        string host_txt;

        int errors;
        int checked;
        int with_request;
        int with_host;
        int with_body;

        function new();
            http_port    = 16'd80;
            min_len      = 12'd16;
            post_txt     = "POST ";
            get_txt      = "GET ";
            host_txt     = "Host: ";
            errors       = 0;
            checked      = 0;
            with_request = 0;
            with_host    = 0;
            with_body    = 0;
            clear_packet();
        endfunction

        function void set_config(logic [15:0] port, logic [11:0] min_payload);
            http_port = port;
            min_len   = min_payload;
        endfunction

        function void clear_packet();
            pos        = 0;
            line_start = 0;
            alive      = CAND_ALL;
            recent[0]  = 8'h00;
            recent[1]  = 8'h00;
            recent[2]  = 8'h00;
            hdr_done   = 1'b0;
            held       = '0;
        endfunction

        // a header line closed by the cr at cr_pos
        function void close_line(int unsigned cr_pos);
            if (alive[CAND_POST]) begin
                held.request_found = 1'b1;
                held.method        = METHOD_POST;
                held.url_offset    = 11'(line_start + 5);
                held.url_len       = 11'(cr_pos - line_start - 5);
            end else if (alive[CAND_GET]) begin
                held.request_found = 1'b1;
                held.method        = METHOD_GET;
                held.url_offset    = 11'(line_start + 4);
                held.url_len       = 11'(cr_pos - line_start - 4);
            end else if (alive[CAND_HOST]) begin
                held.host_found  = 1'b1;
                held.host_offset = 11'(line_start + 6);
                held.host_length = 11'(cr_pos - line_start - 6);
            end
        endfunction

        // one accepted payload byte; the last byte of a packet queues its result
        function void note_byte(hdrs_item_t it);
            int unsigned p;
            int unsigned off;
            int unsigned len;
            bit          scan;
            p    = pos;
            len  = it.payload_len;
            scan = it.is_tcp && (it.payload_len >= min_len)
                   && (it.src_port == http_port || it.dest_port == http_port)
                   && !hdr_done && (p < PAYLOAD_MAX_DEF) && (p >= line_start);
            if (scan) begin
                off = p - line_start;
                if (off < 5 && it.data_byte != post_txt[off]) alive[CAND_POST] = 1'b0;
                if (off < 4 && it.data_byte != get_txt[off])  alive[CAND_GET]  = 1'b0;
                if (off < 6 && it.data_byte != host_txt[off]) alive[CAND_HOST] = 1'b0;
                if (it.data_byte == CH_LF && recent[0] == CH_CR) begin
                    // blank line needs cr lf cr lf with the first cr in range
                    if (p >= 3 && recent[2] == CH_CR && recent[1] == CH_LF && p + 1 < len) begin
                        hdr_done         = 1'b1;
                        held.body_found  = 1'b1;
                        held.body_offset = 12'(p + 1);
                        held.body_len    = 12'(len - p - 1);
                    end else if ((p - 1) + 4 < len) begin
                        close_line(p - 1);
                        line_start = p + 1;
                        alive      = CAND_ALL;
                    end
                end
            end
            recent[2] = recent[1];
            recent[1] = recent[0];
            recent[0] = it.data_byte;
            if (pos < PAYLOAD_MAX_DEF) pos++;
            if (it.last_byte) begin
                expected_q.push_back(held);
                clear_packet();
            end
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // one accepted result item against the oldest queued expectation
        function void check_result(logic [79:0] d);
            hdrs_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result item with no packet outstanding: %h", d);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("request_found", 16'(exp_r.request_found), 16'(d[0]));
            compare_field("method",        16'(exp_r.method),        16'(d[2:1]));
            compare_field("url_offset",    16'(exp_r.url_offset),    16'(d[13:3]));
            compare_field("url_len",       16'(exp_r.url_len),       16'(d[24:14]));
            compare_field("host_found",    16'(exp_r.host_found),    16'(d[25]));
            compare_field("host_offset",   16'(exp_r.host_offset),   16'(d[36:26]));
            compare_field("host_length",   16'(exp_r.host_length),   16'(d[47:37]));
            compare_field("body_found",    16'(exp_r.body_found),    16'(d[48]));
            compare_field("body_offset",   16'(exp_r.body_offset),   16'(d[60:49]));
            compare_field("body_len",      16'(exp_r.body_len),      16'(d[72:61]));
            checked++;
            if (exp_r.request_found) with_request++;
            if (exp_r.host_found) with_host++;
            if (exp_r.body_found) with_body++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

FILE: bench/tb_http_request_header_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_http_request_header_scanner_unit
// self-checking bench for the per-byte http request header scanner
// ----------------------------------------------------------------------------
// Streams packets of payload bytes into the scanner, one byte per item, and
// predicts the per-packet result on the packet's last byte. Most packets are
// http-like header text (request lines, host lines, near-miss prefixes, stray
// cr or lf, blank line, body), the rest are short random bursts and noise
// packets whose packet-wide fields change mid-packet. Several register
// settings are applied between phases, each phase with its own idle pattern
// on the input and result sides, and one phase holds the result side off
// long enough to back the block up.
`timescale 1ns / 1ps

module tb_http_request_header_scanner_unit;

    import hdrs_pkg::*;
    import hdrs_scoreboard_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int HOLD_CYCLES  = 300;   // long result-side hold-off
    localparam int STALL_LIMIT  = 3000;  // cycles with no item moving either way
    localparam int PHASE_BYTES  = 330;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wr_data;

    hdrs_scoreboard sb = new();

    // idle pattern of the current phase, in percent per cycle
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;

    int bytes_sent = 0;
    int packets_sent = 0;

    // bytes of the packet being built
    logic [7:0] pkt[$];

    http_request_header_scanner_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one byte, with random idle cycles ahead of it, until accepted
    task automatic send_byte(input hdrs_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.dest_port, it.src_port, it.payload_len, it.data_byte};
        s_tlast  <= it.last_byte;
        s_tuser  <= it.is_tcp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(it);
        bytes_sent++;
    endtask

    // send pkt as one packet; noisy packets change their packet fields mid-way
    task automatic send_packet(input logic [11:0] len, input logic tcp,
                               input logic [15:0] sp, input logic [15:0] dp,
                               input bit noisy);
        hdrs_item_t it;
        it.payload_len = len;
        it.is_tcp      = tcp;
        it.src_port    = sp;
        it.dest_port   = dp;
        foreach (pkt[i]) begin
            if (noisy) begin
                if ($urandom_range(9) == 0) it.is_tcp = ~it.is_tcp;
                if ($urandom_range(9) == 0) it.src_port = sb.http_port;
                if ($urandom_range(9) == 0) it.dest_port = 16'($urandom_range(65535));
                if ($urandom_range(9) == 0) it.payload_len = 12'($urandom_range(4095));
            end
            it.data_byte = pkt[i];
            it.last_byte = (i == pkt.size() - 1);
            send_byte(it);
        end
        packets_sent++;
    endtask

    task automatic load_text(input string txt);
        pkt.delete();
        for (int k = 0; k < txt.len(); k++) pkt.push_back(txt[k]);
    endtask

    // printable header text with an occasional stray cr
    function automatic logic [7:0] text_char();
        if ($urandom_range(19) == 0) return CH_CR;
        return 8'($urandom_range(126, 32));
    endfunction

    // random bytes leaning toward cr and lf
    task automatic build_noise(input int n);
        int r;
        pkt.delete();
        repeat (n) begin
            r = $urandom_range(3);
            if (r == 0) pkt.push_back(CH_CR);
            else if (r == 1) pkt.push_back(CH_LF);
            else pkt.push_back(8'($urandom_range(255)));
        end
    endtask

    // header-like packet: lines, mostly a blank line, then a body
    task automatic build_request(input int min_size);
        int    n_lines;
        int    r;
        string pre;
        pkt.delete();
        n_lines = $urandom_range(4);
        for (int i = 0; i < n_lines || pkt.size() < min_size; i++) begin
            r = $urandom_range(5);
            if (r == 0) pre = "GET ";
            else if (r == 1) pre = "POST ";
            else if (r == 2) pre = "Host: ";
            else pre = "";
            // near miss: one prefix character replaced
            if (pre.len() > 0 && $urandom_range(5) == 0)
                pre[$urandom_range(pre.len() - 1)] = 8'($urandom_range(126, 33));
            for (int k = 0; k < pre.len(); k++) pkt.push_back(pre[k]);
            repeat ($urandom_range(12)) pkt.push_back(text_char());
            // line end: mostly cr lf, sometimes a lone cr or lf, or none
            r = $urandom_range(19);
            if (r < 17) begin
                pkt.push_back(CH_CR);
                pkt.push_back(CH_LF);
            end else if (r == 17) begin
                pkt.push_back(CH_CR);
            end else if (r == 18) begin
                pkt.push_back(CH_LF);
            end
        end
        if ($urandom_range(99) < 75) begin
            pkt.push_back(CH_CR);
            pkt.push_back(CH_LF);
        end
        repeat ($urandom_range(20)) pkt.push_back(8'($urandom_range(255)));
        if (pkt.size() == 0) pkt.push_back(8'($urandom_range(255)));
    endtask

    // payload_len: mostly the true size, sometimes at least min_len, shorter or random
    function automatic logic [11:0] pick_payload_len(input int actual);
        int r;
        r = $urandom_range(99);
        if (r < 60) return 12'(actual);
        if (r < 80) return 12'($urandom_range(4095, sb.min_len));
        if (r < 90) return 12'((actual > 6) ? actual - $urandom_range(6, 1) : actual);
        return 12'($urandom_range(4095));
    endfunction

    // wait until every expected result is in, then let the pipe settle
    task automatic drain(input int settle);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // both registers, written back to back while the block is idle
    task automatic write_config(input logic [15:0] port, input logic [11:0] min_payload);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_HTTP_PORT;
        cfg_wr_data <= port;
        @(posedge aclk);
        cfg_addr    <= CFG_MIN_LEN;
        cfg_wr_data <= {4'b0, min_payload};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_config(port, min_payload);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit pressure,
                             input bit with_long);
        int          phase_bytes;
        int          r;
        bit          noisy;
        logic        tcp;
        logic [15:0] sp;
        logic [15:0] dp;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        phase_bytes  = 0;
        if (pressure) hold_request = 1'b1;
        while (phase_bytes < PHASE_BYTES || with_long) begin
            noisy = 1'b0;
            if (with_long) begin
                // runs past the position limit
                build_request(2050);
                with_long = 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 78) begin
                    build_request(0);
                end else if (r < 88) begin
                    build_noise($urandom_range(4, 1));
                end else begin
                    build_noise($urandom_range(40, 1));
                    noisy = 1'b1;
                end
            end
            sp = 16'($urandom_range(65535));
            dp = 16'($urandom_range(65535));
            r  = $urandom_range(99);
            if (r < 45) begin
                dp = sb.http_port;
            end else if (r < 65) begin
                sp = sb.http_port;
            end else if (r < 75) begin
                sp = sb.http_port;
                dp = sb.http_port;
            end
            tcp = ($urandom_range(9) != 0);
            send_packet(pick_payload_len(pkt.size()), tcp, sp, dp, noisy);
            phase_bytes += pkt.size();
        end
        s_tvalid <= 1'b0;
        drain(4);
    endtask

    // ------------------------------------------------------------------
    // result side: check each accepted item, then pick the next ready
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with nothing accepted on either side
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_HTTP_PORT;
        cfg_wr_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, at reset register values
        // post line, host line and blank line under a large payload_len
        load_text("POST /\r\nHost: h\r\n\r\n");
        send_packet(12'd2048, 1'b1, 16'd1234, 16'd80, 1'b0);
        // get with an empty url, port match on the source side
        load_text("GET \r\n");
        send_packet(12'd16, 1'b1, 16'd80, 16'd0, 1'b0);
        // single bytes at field extremes, neither one scanned
        pkt = '{8'hff};
        send_packet(12'hfff, 1'b0, 16'hffff, 16'hffff, 1'b0);
        pkt = '{8'h00};
        send_packet(12'd0, 1'b1, 16'h0000, 16'd80, 1'b0);
        s_tvalid <= 1'b0;
        drain(4);

        // random phases, each with its own settings and idle pattern
        write_config(16'd80, 12'd16);
        run_phase(0, 0, 1'b0, 1'b0);
        write_config(16'hffff, 12'd0);
        run_phase(56, 0, 1'b0, 1'b0);
        write_config(16'h0000, 12'd2048);
        run_phase(0, 56, 1'b0, 1'b0);
        write_config(16'($urandom_range(65535)), 12'($urandom_range(64)));
        run_phase(11, 11, 1'b0, 1'b0);
        write_config(16'($urandom_range(65535)), 12'($urandom_range(40)));
        run_phase(0, 0, 1'b1, 1'b0);
        write_config(16'd8080, 12'd16);
        run_phase(0, 56, 1'b0, 1'b0);

        drain(10);
        $display("sent %0d bytes in %0d packets under six register settings and idle patterns",
                 bytes_sent, packets_sent);
        $display("checked %0d results: %0d with request line, %0d with host, %0d with body",
                 sb.checked, sb.with_request, sb.with_host, sb.with_body);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/hdrs_pkg.sv
design/hdrs_in_stage.sv
design/hdrs_scan.sv
design/http_request_header_scanner_unit.sv
bench/hdrs_scoreboard_pkg.sv
bench/tb_http_request_header_scanner_unit.sv
